@@ hdl/cubic_bezier_tessellator_assert.svh @@
// Assertion macros for the cubic Bezier tessellator checker.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef CUBIC_BEZIER_TESSELLATOR_ASSERT_SVH
`define CUBIC_BEZIER_TESSELLATOR_ASSERT_SVH

// Implication into the next cycle, disabled while reset is held.
`define CBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cubic_bezier_tessellator: check failed");

// Property that must hold in the cycle after a reset edge.
`define CBT_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("cubic_bezier_tessellator: reset check failed");

`endif

@@ hdl/cbt_pkg.sv @@
// Shared types and constants for the cubic Bezier tessellator.
// Used by the controller, the datapath and the top level; no dependencies.
package cbt_pkg;

  localparam int COORD_BITS   = 24;
  localparam int MAX_SEGMENTS = 63;
  localparam int SEG_BITS     = $clog2(MAX_SEGMENTS + 1);
  localparam int T_FRAC       = 16;
  localparam int T_BITS       = T_FRAC + 1;
  localparam int DIV_STEPS    = T_BITS;
  localparam int CNT_BITS     = $clog2(DIV_STEPS);
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = DIFF_BITS + T_BITS + 1;
  localparam int NUM_AXES     = 3;
  localparam int NUM_PTS      = 4;
  localparam int NUM_UNITS    = NUM_PTS - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SEG_BITS-1:0]          seg_t;
  typedef logic [T_BITS-1:0]            tpar_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  localparam seg_t  SEG_RESET = seg_t'(30);
  localparam seg_t  SEG_MIN   = seg_t'(1);
  localparam tpar_t T_ONE     = tpar_t'(1) << T_FRAC;
  localparam cnt_t  DIV_LAST  = cnt_t'(DIV_STEPS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch a curve, clear t and index, seed the divider
    logic div_step;  // one quotient bit of 1.0 / segments
    logic mul;       // multiply stage of one interpolation level
    logic src_pts;   // multiply reads control points rather than level results
    logic add;       // add stage of one interpolation level
    logic emit;      // load the output register and step t
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_last;   // current sample is the one at t equal one
  } sts_t;

endpackage

@@ hdl/cbt_datapath.sv @@
// Datapath of the cubic Bezier tessellator: control point store, t step
// divider, t accumulator, nine interpolation units and the output register.
// Depends on cbt_pkg.
module cbt_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  cbt_pkg::seg_t  cfg_segments,
  input  cbt_pkg::coord_t in_pts [cbt_pkg::NUM_AXES][cbt_pkg::NUM_PTS],
  input  cbt_pkg::cmd_t  cmd,
  output cbt_pkg::sts_t  sts,
  output cbt_pkg::coord_t out_point_x,
  output cbt_pkg::coord_t out_point_y,
  output cbt_pkg::coord_t out_point_z,
  output logic           out_last_point
);

  cbt_pkg::seg_t   segments_r;
  cbt_pkg::seg_t   seg_r;
  cbt_pkg::seg_t   seg_eff;
  cbt_pkg::seg_t   rem_r;
  cbt_pkg::seg_t   rem_nxt;
  cbt_pkg::tpar_t  num_r;
  cbt_pkg::tpar_t  quo_r;
  cbt_pkg::tpar_t  t_r;
  cbt_pkg::tpar_t  t_nxt;
  cbt_pkg::seg_t   tr_r;
  cbt_pkg::seg_t   tr_nxt;
  cbt_pkg::seg_t   idx_r;
  logic [cbt_pkg::SEG_BITS:0] trial;
  logic [cbt_pkg::SEG_BITS:0] trial_sub;
  logic [cbt_pkg::SEG_BITS:0] rsum;
  logic [cbt_pkg::SEG_BITS:0] rsub;
  logic            fits;
  logic            wrap;

  cbt_pkg::coord_t pts_r  [cbt_pkg::NUM_AXES][cbt_pkg::NUM_PTS];
  cbt_pkg::coord_t src    [cbt_pkg::NUM_AXES][cbt_pkg::NUM_PTS];
  cbt_pkg::coord_t base_r [cbt_pkg::NUM_AXES][cbt_pkg::NUM_UNITS];
  cbt_pkg::coord_t lv_r   [cbt_pkg::NUM_AXES][cbt_pkg::NUM_UNITS];
  logic signed [cbt_pkg::PROD_BITS-1:0] prod_r [cbt_pkg::NUM_AXES][cbt_pkg::NUM_UNITS];

  // Segments register; zero means one segment.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segments_r <= cbt_pkg::SEG_RESET;
    end else if (cfg_we) begin
      segments_r <= cfg_segments;
    end
  end

  assign seg_eff = (segments_r == '0) ? cbt_pkg::SEG_MIN : segments_r;

  // Restoring divider for 1.0 / segments, one quotient bit per cycle.
  always_comb begin
    trial     = {rem_r, num_r[cbt_pkg::T_BITS-1]};
    trial_sub = trial - {1'b0, seg_r};
    fits      = (trial >= {1'b0, seg_r});
    rem_nxt   = fits ? trial_sub[cbt_pkg::SEG_BITS-1:0] : trial[cbt_pkg::SEG_BITS-1:0];
  end

  // Next t: add the quotient and carry the remainder, so t stays exactly
  // floor(i * 1.0 / segments).
  always_comb begin
    rsum   = {1'b0, tr_r} + {1'b0, rem_r};
    rsub   = rsum - {1'b0, seg_r};
    wrap   = (rsum >= {1'b0, seg_r});
    tr_nxt = wrap ? rsub[cbt_pkg::SEG_BITS-1:0] : rsum[cbt_pkg::SEG_BITS-1:0];
    t_nxt  = t_r + quo_r + cbt_pkg::tpar_t'(wrap);
  end

  assign sts.is_last = (idx_r == seg_r);

  // Sample index, cleared by reset and at each new curve.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + cbt_pkg::seg_t'(1);
    end
  end

  // Curve latch, divider and t accumulator.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pts_r <= in_pts;
      seg_r <= seg_eff;
      rem_r <= '0;
      num_r <= cbt_pkg::T_ONE;
      quo_r <= '0;
      t_r   <= '0;
      tr_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      num_r <= num_r << 1;
      quo_r <= {quo_r[cbt_pkg::T_BITS-2:0], fits};
    end else if (cmd.emit) begin
      t_r  <= t_nxt;
      tr_r <= tr_nxt;
    end
  end

  // Operand selection: level one reads the control points, later levels
  // read the previous level's results. The last slot is a don't-care there.
  always_comb begin
    for (int ax = 0; ax < cbt_pkg::NUM_AXES; ax++) begin
      for (int p = 0; p < cbt_pkg::NUM_UNITS; p++) begin
        src[ax][p] = cmd.src_pts ? pts_r[ax][p] : lv_r[ax][p];
      end
      src[ax][cbt_pkg::NUM_PTS-1] = cmd.src_pts ? pts_r[ax][cbt_pkg::NUM_PTS-1]
                                                : lv_r[ax][cbt_pkg::NUM_UNITS-1];
    end
  end

  // Interpolation units: a + floor((b - a) * t / 1.0), multiply then add.
  for (genvar ax = 0; ax < cbt_pkg::NUM_AXES; ax++) begin : g_axis
    for (genvar u = 0; u < cbt_pkg::NUM_UNITS; u++) begin : g_unit
      logic signed [cbt_pkg::DIFF_BITS-1:0] diff;
      logic signed [cbt_pkg::PROD_BITS-1:0] prod;

      assign diff = cbt_pkg::DIFF_BITS'(src[ax][u+1]) - cbt_pkg::DIFF_BITS'(src[ax][u]);
      assign prod = diff * $signed({1'b0, t_r});

      always_ff @(posedge clk) begin
        if (cmd.mul) begin
          base_r[ax][u] <= src[ax][u];
          prod_r[ax][u] <= prod;
        end
        if (cmd.add) begin
          lv_r[ax][u] <= base_r[ax][u]
                       + prod_r[ax][u][cbt_pkg::T_FRAC +: cbt_pkg::COORD_BITS];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_point_x    <= lv_r[0][0];
      out_point_y    <= lv_r[1][0];
      out_point_z    <= lv_r[2][0];
      out_last_point <= sts.is_last;
    end
  end

endmodule

@@ hdl/cbt_ctrl.sv @@
// Controller of the cubic Bezier tessellator: sequences the divider, the
// three interpolation levels and the output beat for each sample point.
// Depends on cbt_pkg.
module cbt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cbt_pkg::sts_t sts,
  output cbt_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [1:0] LVL_FIRST = 2'd1;
  localparam logic [1:0] LVL_LAST  = 2'd3;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    level_r, level_nxt;
  cbt_pkg::cnt_t cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + cbt_pkg::cnt_t'(1);
        if (cnt_r == cbt_pkg::DIV_LAST) begin
          level_nxt = LVL_FIRST;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        cmd.src_pts = (level_r == LVL_FIRST);
        state_nxt   = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (level_r == LVL_LAST) begin
          state_nxt = S_EMIT;
        end else begin
          level_nxt = level_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          if (sts.is_last) begin
            state_nxt = S_IDLE;
          end else begin
            level_nxt = LVL_FIRST;
            state_nxt = S_MUL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output beat stays valid until taken.
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= LVL_FIRST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/cubic_bezier_tessellator.sv @@
// Cubic Bezier tessellator, de Casteljau evaluation in Q15.8 with t in Q1.16.
// A curve beat first runs the divider for the t step; each point then takes
// three interpolation levels of multiply then add, plus the output load,
// which waits while an output beat is stalled. The interpolation units per
// axis are shared by all levels; a new curve is taken after the last point.
// Synchronous active-low reset: controller idle, no output beat, segments 30.
module cubic_bezier_tessellator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  cbt_pkg::seg_t   cfg_segments,
  input  logic            in_valid,
  output logic            in_ready,
  input  cbt_pkg::coord_t in_p0_x,
  input  cbt_pkg::coord_t in_p0_y,
  input  cbt_pkg::coord_t in_p0_z,
  input  cbt_pkg::coord_t in_p1_x,
  input  cbt_pkg::coord_t in_p1_y,
  input  cbt_pkg::coord_t in_p1_z,
  input  cbt_pkg::coord_t in_p2_x,
  input  cbt_pkg::coord_t in_p2_y,
  input  cbt_pkg::coord_t in_p2_z,
  input  cbt_pkg::coord_t in_p3_x,
  input  cbt_pkg::coord_t in_p3_y,
  input  cbt_pkg::coord_t in_p3_z,
  output logic            out_valid,
  input  logic            out_ready,
  output cbt_pkg::coord_t out_point_x,
  output cbt_pkg::coord_t out_point_y,
  output cbt_pkg::coord_t out_point_z,
  output logic            out_last_point
);

  cbt_pkg::coord_t in_pts [cbt_pkg::NUM_AXES][cbt_pkg::NUM_PTS];
  cbt_pkg::cmd_t   cmd;
  cbt_pkg::sts_t   sts;

  // The segments register takes a beat at any time.
  assign cfg_ready = 1'b1;

  // Control points grouped by axis.
  assign in_pts[0][0] = in_p0_x;
  assign in_pts[0][1] = in_p1_x;
  assign in_pts[0][2] = in_p2_x;
  assign in_pts[0][3] = in_p3_x;
  assign in_pts[1][0] = in_p0_y;
  assign in_pts[1][1] = in_p1_y;
  assign in_pts[1][2] = in_p2_y;
  assign in_pts[1][3] = in_p3_y;
  assign in_pts[2][0] = in_p0_z;
  assign in_pts[2][1] = in_p1_z;
  assign in_pts[2][2] = in_p2_z;
  assign in_pts[2][3] = in_p3_z;

  cbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid),
    .cfg_segments   (cfg_segments),
    .in_pts         (in_pts),
    .cmd            (cmd),
    .sts            (sts),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_last_point (out_last_point)
  );

endmodule

@@ hdl/cbt_checker.sv @@
// Port-level checker for the cubic Bezier tessellator, bound to the top level.
// Depends on cbt_pkg and cubic_bezier_tessellator_assert.svh.
`include "cubic_bezier_tessellator_assert.svh"

module cbt_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input cbt_pkg::coord_t out_point_x,
  input cbt_pkg::coord_t out_point_y,
  input cbt_pkg::coord_t out_point_z,
  input logic            out_last_point
);

  // A stalled result beat keeps its point.
  `CBT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_z) && $stable(out_last_point))

  // A curve beat starts work, so no second curve is taken right behind it.
  `CBT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // While a point other than the last one waits, the curve is still in work.
  `CBT_ASSERT_NEXT(a_busy_mid_curve, out_valid && !out_ready && !out_last_point, !in_ready)

  // Reset leaves the block idle with no pending result.
  `CBT_ASSERT_AFTER_RESET(a_reset_idle, !out_valid && in_ready)

endmodule

bind cubic_bezier_tessellator cbt_checker u_cbt_checker (.*);

@@ bench/tb.sv @@
// Self-checking testbench for cubic_bezier_tessellator: drives whole curves and
// checks every sampled point against a built-in de Casteljau predictor.
// Depends on cbt_pkg and the cubic_bezier_tessellator RTL.
module tb;
  import cbt_pkg::*;

  localparam coord_t COORD_MIN = coord_t'(1) << (COORD_BITS - 1);
  localparam coord_t COORD_MAX = ~COORD_MIN;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 39;
  // Segment counts for the random phases, extremes included (0 acts as 1).
  localparam int PHASE_SEGS [NUM_PHASES] = '{1, 2, 63, 5, 0, 3, 8, 63, 4, 16, 7, 1};

  typedef struct {
    coord_t pt [NUM_PTS][NUM_AXES];
  } curve_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;

  // Holds the segment setting and the queue of points still owed by the block.
  class bezier_point_scoreboard;
    seg_t   segments;
    point_t owed_points [$];
    int     errors;

    function new();
      segments = SEG_RESET;
      errors = 0;
    endfunction

    function int pending();
      return owed_points.size();
    endfunction

    // One interpolation level; the arithmetic shift floors toward minus infinity.
    function longint blend(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> T_FRAC);
    endfunction

    function longint casteljau_axis(longint c0, longint c1, longint c2, longint c3,
                                    longint t);
      longint a, b, c, d, e;
      a = blend(c0, c1, t);
      b = blend(c1, c2, t);
      c = blend(c2, c3, t);
      d = blend(a, b, t);
      e = blend(b, c, t);
      return blend(d, e, t);
    endfunction

    // Works out every sample point of an accepted curve beat.
    function void note_curve(curve_t cv);
      longint segs, t;
      longint coord [NUM_AXES];
      point_t pt;
      segs = (segments == 0) ? 1 : longint'(segments);
      if (segs > MAX_SEGMENTS) segs = MAX_SEGMENTS;
      for (longint i = 0; i <= segs; i++) begin
        t = (i * longint'(T_ONE)) / segs;
        for (int a = 0; a < NUM_AXES; a++) begin
          coord[a] = casteljau_axis(longint'(cv.pt[0][a]), longint'(cv.pt[1][a]),
                                    longint'(cv.pt[2][a]), longint'(cv.pt[3][a]), t);
        end
        pt.x = coord_t'(coord[0]);
        pt.y = coord_t'(coord[1]);
        pt.z = coord_t'(coord[2]);
        pt.last = (i == segs);
        owed_points.push_back(pt);
      end
    endfunction

    // Compares one output beat with the oldest owed point.
    function void check_point(coord_t x, coord_t y, coord_t z, logic last);
      point_t want;
      if (owed_points.size() == 0) begin
        $error("unexpected point: x %0d y %0d z %0d last %0b", x, y, z, last);
        errors++;
        return;
      end
      want = owed_points.pop_front();
      if (x !== want.x) begin
        $error("point_x mismatch: expected %0d, actual %0d", want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $error("point_y mismatch: expected %0d, actual %0d", want.y, y);
        errors++;
      end
      if (z !== want.z) begin
        $error("point_z mismatch: expected %0d, actual %0d", want.z, z);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_point mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  seg_t   cfg_segments = '0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  curve_t in_curve = '{pt: '{default: '0}};
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_point_x, out_point_y, out_point_z;
  logic   out_last_point;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bezier_point_scoreboard points_sb = new();

  cubic_bezier_tessellator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_segments   (cfg_segments),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_p0_x        (in_curve.pt[0][0]),
    .in_p0_y        (in_curve.pt[0][1]),
    .in_p0_z        (in_curve.pt[0][2]),
    .in_p1_x        (in_curve.pt[1][0]),
    .in_p1_y        (in_curve.pt[1][1]),
    .in_p1_z        (in_curve.pt[1][2]),
    .in_p2_x        (in_curve.pt[2][0]),
    .in_p2_y        (in_curve.pt[2][1]),
    .in_p2_z        (in_curve.pt[2][2]),
    .in_p3_x        (in_curve.pt[3][0]),
    .in_p3_y        (in_curve.pt[3][1]),
    .in_p3_z        (in_curve.pt[3][2]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_last_point (out_last_point)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random on each cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted output beat goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      points_sb.check_point(out_point_x, out_point_y, out_point_z, out_last_point);
    end
  end

  // Builds a curve whose axes share one profile, mirrored on y and scrambled on z.
  function automatic curve_t profile_curve(coord_t a0, coord_t a1, coord_t a2, coord_t a3);
    curve_t cv;
    coord_t prof [NUM_PTS];
    prof = '{a0, a1, a2, a3};
    for (int k = 0; k < NUM_PTS; k++) begin
      cv.pt[k][0] = prof[k];
      cv.pt[k][1] = ~prof[k];
      cv.pt[k][2] = prof[k] ^ coord_t'(24'h5a5a5a);
    end
    return cv;
  endfunction

  // Mostly full-range coordinates, some extremes, some tight local curves.
  function automatic curve_t random_curve();
    curve_t cv;
    int unsigned kind;
    coord_t base [NUM_AXES];
    kind = $urandom_range(99);
    for (int a = 0; a < NUM_AXES; a++) base[a] = coord_t'($urandom());
    for (int k = 0; k < NUM_PTS; k++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (kind < 70) begin
          cv.pt[k][a] = coord_t'($urandom());
        end else if (kind < 85) begin
          case ($urandom_range(4))
            0: cv.pt[k][a] = COORD_MIN;
            1: cv.pt[k][a] = COORD_MAX;
            2: cv.pt[k][a] = '0;
            3: cv.pt[k][a] = '1;
            default: cv.pt[k][a] = coord_t'(1);
          endcase
        end else begin
          cv.pt[k][a] = base[a] + coord_t'($urandom_range(1023)) - coord_t'(512);
        end
      end
    end
    return cv;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_curve(input curve_t cv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_curve <= cv;
    do @(posedge clk); while (!in_ready);
    points_sb.note_curve(cv);
    @(negedge clk);
  endtask

  // Register writes only happen once every owed point has arrived.
  task automatic write_segments(input seg_t value);
    cfg_valid <= 1'b1;
    cfg_segments <= value;
    do @(posedge clk); while (!cfg_ready);
    points_sb.segments = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    do @(negedge clk); while (points_sb.pending() != 0);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed curves at the reset setting: flat, extreme and full-scale ramps.
    send_curve(profile_curve('0, '0, '0, '0));
    send_curve(profile_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_curve(profile_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_curve(profile_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_curve(profile_curve(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    send_curve(profile_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    send_curve(profile_curve('0, '1, coord_t'(1), '0));
    drain_points();

    // Zero segments behaves as one: only the end points come out.
    write_segments(seg_t'(0));
    send_curve(profile_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_curve(random_curve());
    drain_points();

    // Largest and smallest segment counts on full-scale and random curves.
    write_segments(seg_t'(MAX_SEGMENTS));
    send_curve(profile_curve(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    send_curve(profile_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    drain_points();
    write_segments(SEG_MIN);
    send_curve(profile_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    send_curve(random_curve());
    drain_points();

    // Random phases, cycling through the idle and stall patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_segments(seg_t'(PHASE_SEGS[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_curve(random_curve());
      drain_points();
    end

    // Catch any stray beat after the last owed point.
    repeat (40) @(posedge clk);
    if (points_sb.errors == 0) begin
      $display("PASS cubic_bezier_tessellator");
    end else begin
      $display("FAIL cubic_bezier_tessellator");
    end
    $finish;
  end

  initial begin
    #36000000;
    $display("FAIL cubic_bezier_tessellator");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cbt_pkg.sv
hdl/cbt_datapath.sv
hdl/cbt_ctrl.sv
hdl/cubic_bezier_tessellator.sv
hdl/cbt_checker.sv
bench/tb.sv
